[rtl/pstc_pkg.sv]
// Package for the PI speed throttle controller: register indexes, function codes,
// widths and shared types. No dependencies.
package pstc_pkg;
  localparam int unsigned NumRegs = 6;
  localparam logic [2:0] RegKp  = 3'd0;
  localparam logic [2:0] RegKi  = 3'd1;
  localparam logic [2:0] RegG   = 3'd2;
  localparam logic [2:0] RegOfs = 3'd3;
  localparam logic [2:0] RegSc  = 3'd4;
  localparam logic [2:0] RegOff = 3'd5;

  localparam logic [1:0] FuncStep    = 2'd0;
  localparam logic [1:0] FuncEnable  = 2'd1;
  localparam logic [1:0] FuncDisable = 2'd2;
  localparam logic [1:0] FuncApply   = 2'd3;

  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;
endpackage

[rtl/pstc_mul.sv]
// Bit-serial signed multiplier, 64 by 32 bits, one multiplier bit per cycle.
// Depends on pstc_pkg.
module pstc_mul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [63:0]     a_i,
  input  logic signed [31:0]     b_i,
  output logic                   done_o,
  output logic signed [95:0]     p_o
);
  import pstc_pkg::*;
  logic [5:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic signed [95:0] acc_q, acc_d;
  logic signed [95:0] a_q, a_d;
  logic [31:0]        b_q, b_d;

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; acc_d = acc_q; a_d = a_q; b_d = b_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1; cnt_d = 6'd0; acc_d = '0;
      a_d = 96'(a_i); b_d = b_i;
    end else if (busy_q) begin
      // top multiplier bit carries negative weight
      if (b_q[0]) acc_d = (cnt_q == 6'd31) ? acc_q - a_q : acc_q + a_q;
      a_d = a_q <<< 1;
      b_d = b_q >> 1;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) busy_d = 1'b0;
    end
    if (busy_q && !busy_d && !start_i) done_o = 1'b1;
  end
  assign p_o = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; a_q <= a_d; b_q <= b_d;
  end
endmodule

[rtl/pi_speed_throttle_controller.sv]
// PI speed throttle controller, top level: APB registers, stream ports, sequencer.
// Depends on pstc_pkg and pstc_mul.
// A step word runs six bit-serial products in the shared multiplier, then a finish state,
// then the result goes through the output register; enable, disable and apply words skip
// the products. A new word is taken only while the sequencer is idle and no result waits.
// Reset (rst_ni low, asynchronous) clears registers, integral and motor/PWM flags.
module pi_speed_throttle_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: velocity[31:0], measured_rpm[63:32], step_time[87:64], throttle_value[98:88]
  input  logic [103:0] s_axis_tdata,
  // tuser: func[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: throttle[10:0], duty_write[11], duty_ns[32:12], pwm_on[33], motors_on[34]
  output logic [39:0]  m_axis_tdata
);
  import pstc_pkg::*;

  localparam logic [3:0] SIdle = 4'd0, SSp = 4'd1, SErr = 4'd2, SInt = 4'd3,
                         SKp = 4'd4, SKi = 4'd5, SKl = 4'd6, SSc = 4'd7,
                         SFin = 4'd8, SOut = 4'd9;

  logic signed [31:0] kp_q, ki_q, g_q, ofs_q, sc_q;
  logic signed [10:0] off_q;
  logic signed [47:0] integ_q;
  logic               mot_q, pwm_q;
  logic [3:0]         st_q;
  logic signed [31:0] vel_q, rpm_q, err_q;
  logic [23:0]        dt_q;
  logic signed [10:0] tv_q;
  logic signed [63:0] eff_q;
  logic [39:0]        out_q;
  logic               ov_q;
  // output register: lets the next word in while a result waits
  logic [39:0]        mdata_q;
  logic               mvalid_q;

  logic               wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[4:2])
      RegKp:   prdata = kp_q;
      RegKi:   prdata = ki_q;
      RegG:    prdata = g_q;
      RegOfs:  prdata = ofs_q;
      RegSc:   prdata = sc_q;
      RegOff:  prdata = 32'(unsigned'(off_q));
      default: prdata = '0;
    endcase
  end

  // shared multiplier
  logic               m_start, m_done;
  logic signed [63:0] m_a;
  logic signed [31:0] m_b;
  logic signed [95:0] m_p;
  pstc_mul u_mul (.clk_i, .rst_ni, .start_i(m_start), .a_i(m_a), .b_i(m_b),
                  .done_o(m_done), .p_o(m_p));

  function automatic logic [20:0] duty(input logic signed [10:0] v);
    logic signed [11:0] c;
    c = (v > 11'sd1000) ? 12'sd1000 : (v < -11'sd1000) ? -12'sd1000 : 12'(v);
    return 21'((32'(c) + 32'sd1000) * 32'sd1000);
  endfunction

  function automatic logic signed [63:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  logic signed [63:0] sp_w, inc_w, nint_w, raw_w, d_w, thr_w;
  logic signed [95:0] mag_w;
  always_comb begin
    sp_w  = 64'(m_p >>> 16) + 64'(ofs_q);
    inc_w = 64'(m_p >>> 24);
    nint_w = 64'(integ_q) + inc_w;
    if (nint_w > 64'sh7FFF_FFFF_FFFF) nint_w = 64'sh7FFF_FFFF_FFFF;
    if (nint_w < -64'sh8000_0000_0000) nint_w = -64'sh8000_0000_0000;
    mag_w = m_p[95] ? -m_p : m_p;
    raw_w = m_p[95] ? -64'(mag_w >>> 32) : 64'(mag_w >>> 32);
    d_w = raw_w - 64'(tv_q);
    if (d_w > 64'sd2) d_w = 64'sd2;
    if (d_w < -64'sd2) d_w = -64'sd2;
    thr_w = 64'(tv_q) + d_w;
    if (thr_w < 0) thr_w = 0;
    if (thr_w > 64'sd1000) thr_w = 64'sd1000;
  end

  always_comb begin
    m_a = '0; m_b = '0;
    unique case (st_q)
      SSp:  begin m_a = 64'(vel_q); m_b = g_q; end
      SInt: begin m_a = 64'(err_q); m_b = 32'(signed'({1'b0, dt_q})); end
      SKp:  begin m_a = 64'(err_q); m_b = kp_q; end
      SKi:  begin m_a = 64'(integ_q >>> 16); m_b = ki_q; end
      SKl:  begin m_a = 64'({integ_q[15:0]}); m_b = ki_q; end
      SSc:  begin m_a = eff_q; m_b = sc_q; end
      default: ;
    endcase
  end

  assign s_axis_tready = (st_q == SIdle) && !ov_q;
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
  logic started_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0; ki_q <= '0; g_q <= '0; ofs_q <= '0; sc_q <= '0; off_q <= '0;
      integ_q <= '0; mot_q <= 1'b0; pwm_q <= 1'b0; st_q <= SIdle; ov_q <= 1'b0;
      started_q <= 1'b0; mvalid_q <= 1'b0; mdata_q <= '0;
    end else begin
      if (wr) begin
        unique case (paddr[4:2])
          RegKp:  kp_q  <= pwdata;
          RegKi:  ki_q  <= pwdata;
          RegG:   g_q   <= pwdata;
          RegOfs: ofs_q <= pwdata;
          RegSc:  sc_q  <= pwdata;
          RegOff: off_q <= pwdata[10:0];
          default: ;
        endcase
      end
      // move the finished word on once the output register is free
      if (ov_q && (!mvalid_q || m_axis_tready)) ov_q <= 1'b0;
      if (!mvalid_q || m_axis_tready) begin
        mvalid_q <= ov_q;
        mdata_q  <= out_q;
      end
      unique case (st_q)
        SIdle: if (s_axis_tvalid && s_axis_tready) begin
          unique case (s_axis_tuser)
            FuncStep: st_q <= SSp;
            FuncEnable: begin
              integ_q <= '0; mot_q <= 1'b1; pwm_q <= 1'b1; ov_q <= 1'b1;
              out_q <= {5'd0, 1'b1, 1'b1, duty(off_q), 1'b1, off_q};
            end
            FuncDisable: begin
              integ_q <= '0; mot_q <= 1'b0; pwm_q <= 1'b0; ov_q <= 1'b1;
              out_q <= {5'd0, 1'b0, 1'b0, mot_q ? duty(off_q) : 21'd0, mot_q, off_q};
            end
            default: begin
              ov_q <= 1'b1;
              out_q <= {5'd0, mot_q, pwm_q,
                        mot_q ? duty(s_axis_tdata[98:88]) : 21'd0, mot_q,
                        s_axis_tdata[98:88]};
            end
          endcase
        end
        SSp, SInt, SKp, SKi, SKl, SSc: begin
          if (!started_q) started_q <= 1'b1;
          else if (m_done) begin
            started_q <= 1'b0;
            unique case (st_q)
              SSp:  begin err_q <= 32'(sat32(sp_w - 64'(rpm_q))); st_q <= SInt; end
              SInt: begin integ_q <= 48'(nint_w); st_q <= SKp; end
              SKp:  begin eff_q <= 64'(m_p >>> 16); st_q <= SKi; end
              SKi:  begin eff_q <= eff_q + 64'(m_p); st_q <= SKl; end
              SKl:  begin eff_q <= sat32(eff_q + 64'(m_p >>> 16)); st_q <= SSc; end
              default: begin eff_q <= thr_w; st_q <= SFin; end
            endcase
          end
        end
        SFin: begin
          ov_q <= 1'b1; st_q <= SIdle;
          out_q <= {5'd0, mot_q, pwm_q, 21'd0, 1'b0, eff_q[10:0]};
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  // operand capture and multiplier launch
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      vel_q <= s_axis_tdata[31:0]; rpm_q <= s_axis_tdata[63:32];
      dt_q <= s_axis_tdata[87:64]; tv_q <= s_axis_tdata[98:88];
    end
  end
  always_comb begin
    m_start = 1'b0;
    if ((st_q == SSp || st_q == SInt || st_q == SKp || st_q == SKi ||
         st_q == SKl || st_q == SSc) && !started_q) m_start = 1'b1;
  end
endmodule

[test/pi_speed_throttle_controller_tb.sv]
// Testbench for pi_speed_throttle_controller: APB register set-up, stream stimulus, and
// a scoreboard holding its own fixed-point predictor. Depends on pstc_pkg and the RTL.
`timescale 1ns / 100ps

module pi_speed_throttle_controller_tb;
  import pstc_pkg::*;

  typedef struct packed {
    logic [10:0] throttle;
    logic        duty_write;
    logic [20:0] duty_ns;
    logic        pwm_on;
    logic        motors_on;
  } throttle_word_t;

  // Scoreboard: tracks controller state and holds expected output words in order.
  class throttle_scoreboard;
    localparam longint I32Min = -64'sd2147483648;
    localparam longint I32Max = 64'sd2147483647;
    localparam longint IntgMax = 64'sh7FFF_FFFF_FFFF;
    localparam longint IntgMin = -64'sh8000_0000_0000;

    logic [31:0]    regs [NumRegs];
    longint         integ;
    bit             motors;
    bit             pwm;
    throttle_word_t pending [$];
    int             errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      integ = 0;
      motors = 0;
      pwm = 0;
      errors = 0;
    endfunction

    static function longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    static function logic [20:0] pulse_ns(longint v);
      return 21'((clip(v, -1000, 1000) + 1000) * 1000);
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      regs[idx] = (idx == RegOff) ? {21'd0, val[10:0]} : val;
    endfunction

    // Works out the output word an accepted input word causes.
    function void note_input(logic [1:0] fn, logic [103:0] d);
      longint vel, rpm, dt, tv, off, sp, err, lo, hi, eff, prod, raw, dlt;
      throttle_word_t w;
      vel = longint'($signed(d[31:0]));
      rpm = longint'($signed(d[63:32]));
      dt  = longint'(d[87:64]);
      tv  = longint'($signed(d[98:88]));
      off = longint'($signed(regs[RegOff][10:0]));
      w = '0;
      case (fn)
        FuncStep: begin
          sp  = ((vel * longint'($signed(regs[RegG]))) >>> 16) + longint'($signed(regs[RegOfs]));
          err = clip(sp - rpm, I32Min, I32Max);
          integ = clip(integ + ((err * dt) >>> 24), IntgMin, IntgMax);
          lo  = integ & 64'hFFFF;
          hi  = integ >>> 16;
          eff = ((longint'($signed(regs[RegKp])) * err) >>> 16)
                + longint'($signed(regs[RegKi])) * hi
                + ((longint'($signed(regs[RegKi])) * lo) >>> 16);
          eff  = clip(eff, I32Min, I32Max);
          prod = eff * longint'($signed(regs[RegSc]));
          raw  = (prod >= 0) ? (prod >>> 32) : -((-prod) >>> 32);
          dlt  = clip(raw - tv, -2, 2);
          w.throttle = 11'(clip(tv + dlt, 0, 1000));
        end
        FuncEnable: begin
          integ = 0;
          motors = 1;
          pwm = 1;
          w.throttle = 11'(off);
          w.duty_write = 1;
          w.duty_ns = pulse_ns(off);
        end
        FuncDisable: begin
          w.throttle = 11'(off);
          if (motors) begin
            w.duty_write = 1;
            w.duty_ns = pulse_ns(off);
          end
          pwm = 0;
          integ = 0;
          motors = 0;
        end
        default: begin
          w.throttle = 11'(tv);
          if (motors) begin
            w.duty_write = 1;
            w.duty_ns = pulse_ns(tv);
          end
        end
      endcase
      w.pwm_on = pwm;
      w.motors_on = motors;
      pending.push_back(w);
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    task check_result(logic [39:0] d);
      throttle_word_t e;
      if (pending.size() == 0) begin
        report("unexpected word", int'(d[34:0]), 0);
        return;
      end
      e = pending.pop_front();
      if (d[10:0] !== e.throttle)   report("throttle", d[10:0], e.throttle);
      if (d[11] !== e.duty_write)   report("duty_write", d[11], e.duty_write);
      if (d[32:12] !== e.duty_ns)   report("duty_ns", d[32:12], e.duty_ns);
      if (d[33] !== e.pwm_on)       report("pwm_on", d[33], e.pwm_on);
      if (d[34] !== e.motors_on)    report("motors_on", d[34], e.motors_on);
    endtask
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  // tdata: velocity, measured_rpm, step_time, throttle_value, pad (lowest first)
  logic [103:0] s_axis_tdata = '0;
  // tuser: func
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  // tdata: throttle, duty_write, duty_ns, pwm_on, motors_on (lowest first)
  logic [39:0]  m_axis_tdata;

  int idle_pct  = 0;  // sender gap chance per word, percent
  int stall_pct = 0;  // receiver stall chance per cycle, percent

  throttle_scoreboard sb = new();

  pi_speed_throttle_controller DUT (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Receiver: check on each accepted word, then choose next tready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Register write: setup cycle then access cycle.
  task write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  // Waits until every expected word has arrived, plus margin for the pipeline.
  task drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task send_word(logic [1:0] fn, logic [31:0] vel, logic [31:0] rpm, logic [23:0] dt,
                 logic [10:0] tv);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {5'd0, tv, dt, rpm, vel};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(fn, {5'd0, tv, dt, rpm, vel});
  endtask

  function automatic logic [31:0] pick_gain(int mode);
    case (mode)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task program_all(int mode);
    write_reg(RegKp,  pick_gain(mode));
    write_reg(RegKi,  pick_gain(mode));
    write_reg(RegG,   pick_gain(mode));
    write_reg(RegOfs, pick_gain(mode));
    write_reg(RegSc,  (mode == 3) ? 32'($urandom_range(1 << 22, 1 << 26)) : pick_gain(mode));
    write_reg(RegOff, mode == 0 ? 32'd1000 : mode == 1 ? 32'h400 : 32'($urandom_range(0, 2047)));
  endtask

  task random_word();
    int r;
    logic [10:0] tv;
    r = $urandom_range(99);
    tv = ($urandom_range(9) == 0) ? 11'($urandom()) : 11'($signed($urandom_range(0, 2000)) - 1000);
    if (r < 70)
      send_word(FuncStep, ($urandom_range(3) == 0) ? $urandom() : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)),
                $urandom(), 24'($urandom()), tv);
    else if (r < 82) send_word(FuncApply, $urandom(), $urandom(), 24'($urandom()), tv);
    else if (r < 91) send_word(FuncEnable, $urandom(), $urandom(), 24'($urandom()), tv);
    else             send_word(FuncDisable, $urandom(), $urandom(), 24'($urandom()), tv);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: reset settings first, then the extremes.
    send_word(FuncApply, '0, '0, '0, 11'd500);          // apply while disabled
    send_word(FuncDisable, '0, '0, '0, '0);             // disable while disabled
    send_word(FuncStep, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 11'h400); // step while disabled
    drain();
    program_all(0);
    send_word(FuncEnable, '0, '0, '0, '0);
    send_word(FuncStep, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 11'd1000);
    send_word(FuncStep, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF, -11'sd1000);
    send_word(FuncStep, '0, '0, '0, 11'd0);
    send_word(FuncApply, '0, '0, '0, 11'h7FF);
    send_word(FuncApply, '0, '0, '0, 11'h400);          // outside range: duty clamped
    send_word(FuncApply, '0, '0, '0, 11'h3FF);
    send_word(FuncDisable, '0, '0, '0, '0);             // disable while enabled
    drain();
    program_all(1);
    send_word(FuncEnable, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 11'h7FF);
    send_word(FuncStep, 32'h8000_0000, 32'h7FFF_FFFF, 24'h00_0001, 11'd2);
    send_word(FuncStep, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 11'd999);
    send_word(FuncDisable, '0, '0, '0, '0);
    drain();

    // Random phases: each with its own settings and idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      program_all(ph == 3 ? 2 : 3);
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 61 : 27) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 61 : 27) : 0;
      send_word(FuncEnable, '0, '0, '0, '0);
      for (int n = 0; n < 420; n++) begin
        random_word();
        if (ph == 1 && n == 200) drain();   // hold off until the output side is empty
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) $display("[pi_speed_throttle_controller] OK");
    else                $display("[pi_speed_throttle_controller] ERROR");
    $finish;
  end

  initial begin
    #15ms;
    $display("[pi_speed_throttle_controller] ERROR");
    $finish;
  end
endmodule

[sim.f]
rtl/pstc_pkg.sv
rtl/pstc_mul.sv
rtl/pi_speed_throttle_controller.sv
test/pi_speed_throttle_controller_tb.sv
